>>> sv/html_markup_stripper_top_defines.svh
// Assertion macros used by the RTL file hms_back.sv.
`ifndef HTML_MARKUP_STRIPPER_TOP_DEFINES_SVH
`define HTML_MARKUP_STRIPPER_TOP_DEFINES_SVH

// Checked on every clock edge outside reset.
`define HMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define HMS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> sv/hms_pkg.sv
package hms_pkg;

    localparam int MAX_ENT = 24;
    localparam int ENT_CW  = $clog2(MAX_ENT + 1);
    localparam int ENT_AW  = $clog2(MAX_ENT);
    localparam int QDEPTH  = 4;
    localparam int QAW     = $clog2(QDEPTH);

    localparam logic [7:0] C_LT    = 8'h3C;
    localparam logic [7:0] C_GT    = 8'h3E;
    localparam logic [7:0] C_AMP   = 8'h26;
    localparam logic [7:0] C_SEMI  = 8'h3B;
    localparam logic [7:0] C_NL    = 8'h0A;
    localparam logic [7:0] C_SP    = 8'h20;
    localparam logic [7:0] C_BANG  = 8'h21;
    localparam logic [7:0] C_DASH  = 8'h2D;
    localparam logic [7:0] C_LOW_S = 8'h73;
    localparam logic [7:0] C_LOW_C = 8'h63;
    localparam logic [7:0] C_LOW_T = 8'h74;

    localparam logic [2:0] M_TEXT    = 3'd0;
    localparam logic [2:0] M_LT      = 3'd1;
    localparam logic [2:0] M_COMMENT = 3'd2;
    localparam logic [2:0] M_SCRIPT  = 3'd3;
    localparam logic [2:0] M_STYLE   = 3'd4;
    localparam logic [2:0] M_TAG     = 3'd5;

    localparam logic [1:0] G_NONE  = 2'd0;
    localparam logic [1:0] G_SPACE = 2'd1;
    localparam logic [1:0] G_LINE  = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       doc_end;
        logic       initial_gap;
        logic       ws;
    } t_item;

    function automatic logic [7:0] f_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic f_is_ws(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [2:0] f_open_len(input logic [2:0] mode);
        case (mode)
            M_COMMENT: return 3'd3;
            M_SCRIPT:  return 3'd6;
            default:   return 3'd5;
        endcase
    endfunction

    function automatic logic [7:0] f_open_char(input logic [2:0] mode, input logic [2:0] k);
        logic [47:0] s;
        s = (mode == M_COMMENT) ? {"!--", 24'd0} :
            (mode == M_SCRIPT)  ? "script" : {"style", 8'd0};
        return s[47 - 8 * k -: 8];
    endfunction

    function automatic logic [3:0] f_close_len(input logic [2:0] mode);
        case (mode)
            M_COMMENT: return 4'd3;
            M_SCRIPT:  return 4'd9;
            default:   return 4'd8;
        endcase
    endfunction

    function automatic logic [7:0] f_close_char(input logic [2:0] mode, input logic [3:0] k);
        logic [71:0] s;
        s = (mode == M_COMMENT) ? {"-->", 48'd0} :
            (mode == M_SCRIPT)  ? "</script>" : {"</style>", 8'd0};
        return s[71 - 8 * k -: 8];
    endfunction

endpackage

>>> sv/hms_if.sv
interface hms_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       doc_end;
    logic       initial_gap;
    modport source(output valid, in_byte, doc_end, initial_gap, input ready);
    modport sink(input valid, in_byte, doc_end, initial_gap, output ready);
endinterface

interface hms_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_marker;
    logic       last_of_run;
    modport source(output valid, out_byte, end_marker, last_of_run, input ready);
    modport sink(input valid, out_byte, end_marker, last_of_run, output ready);
endinterface

>>> sv/hms_front.sv
module hms_front
    import hms_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    hms_in_if.sink i_in,
    output t_item  o_item,
    output logic   o_valid,
    input  logic   i_pop
);

    t_item            r_q [QDEPTH];
    logic [QAW-1:0]   r_wr;
    logic [QAW-1:0]   r_rd;
    logic [QAW:0]     r_cnt;
    logic             push;
    logic             pop;

    assign i_in.ready = r_cnt != (QAW + 1)'(QDEPTH);
    assign push       = i_in.valid && i_in.ready;
    assign o_valid    = r_cnt != '0;
    assign pop        = i_pop && o_valid;
    assign o_item     = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= '{in_byte: i_in.in_byte, doc_end: i_in.doc_end,
                           initial_gap: i_in.initial_gap, ws: f_is_ws(i_in.in_byte)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QAW + 1)'(push) - (QAW + 1)'(pop);
        end
    end

endmodule

>>> sv/hms_back.sv
`include "html_markup_stripper_top_defines.svh"

module hms_back
    import hms_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_item     i_item,
    input  logic      i_valid,
    output logic      o_pop,
    hms_out_if.source o_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAIN = 3'd1;
    localparam logic [2:0] S_AMP  = 3'd2;
    localparam logic [2:0] S_RPL  = 3'd3;
    localparam logic [2:0] S_MARK = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [7:0]        r_c, n_c;
    logic              r_ws, n_ws;
    logic              r_last, n_last;
    logic [2:0]        r_mode, n_mode;
    logic [2:0]        r_om, n_om;
    logic [3:0]        r_cm, n_cm;
    logic [1:0]        r_pg, n_pg;
    logic [ENT_CW-1:0] r_ec, n_ec;
    logic              r_eo, n_eo;
    logic              r_ds, n_ds;
    logic [ENT_CW-1:0] r_rk, n_rk;
    logic [ENT_CW-1:0] r_rn, n_rn;
    logic              r_from_end, n_from_end;
    logic [7:0]        r_hold [MAX_ENT];

    logic              r_stg_v;
    logic [7:0]        r_stg_byte;
    logic              r_stg_mark;
    logic              r_out_v;
    logic [7:0]        r_out_byte;
    logic              r_out_mark;
    logic              r_out_last;

    logic [7:0]        p_c, p_lc, p_want;
    logic              p_ent, p_adv, p_emit;
    logic [7:0]        p_byte;
    logic [2:0]        p_mode, p_om;
    logic [3:0]        p_cm, p_k;
    logic [1:0]        p_pg;
    logic              p_eo;
    logic [ENT_CW-1:0] p_ec;

    logic              e_v, e_mark, fin, pop_req, h_we, adv;
    logic [7:0]        e_byte;
    logic              out_free, stall, go;
    logic [7:0]        gap_byte;

    assign gap_byte = (r_pg == G_LINE) ? C_NL : C_SP;

    always_comb begin
        p_c    = (r_state == S_RPL) ? r_hold[r_rk[ENT_AW-1:0]] : r_c;
        p_lc   = f_lower(p_c);
        p_ent  = r_state != S_RPL;
        p_mode = r_mode;
        p_om   = r_om;
        p_cm   = r_cm;
        p_pg   = r_pg;
        p_eo   = r_eo;
        p_ec   = r_ec;
        p_adv  = 1'b1;
        p_emit = 1'b0;
        p_byte = p_c;
        p_want = '0;
        p_k    = r_cm;
        case (r_mode)
            M_TEXT: begin
                if (p_c == C_LT) begin
                    p_mode = M_LT;
                    p_om   = '0;
                    p_cm   = '0;
                end else if (p_c == C_AMP && p_ent) begin
                    p_eo = 1'b1;
                    p_ec = '0;
                end else if (p_c == C_NL) begin
                    p_pg = G_LINE;
                end else if (f_is_ws(p_c)) begin
                    if (r_pg != G_LINE) p_pg = G_SPACE;
                end else if (r_pg != G_NONE) begin
                    p_emit = 1'b1;
                    p_byte = gap_byte;
                    p_pg   = G_NONE;
                    p_adv  = 1'b0;
                end else begin
                    p_emit = 1'b1;
                end
            end
            M_LT: begin
                if (r_om == '0 && p_c == C_BANG) begin
                    p_mode = M_COMMENT;
                    p_om   = 3'd1;
                end else if (r_om == '0 && p_lc == C_LOW_S) begin
                    p_om = 3'd1;
                end else if (r_om != '0 && p_lc == C_LOW_C) begin
                    p_mode = M_SCRIPT;
                    p_om   = 3'd2;
                end else if (r_om != '0 && p_lc == C_LOW_T) begin
                    p_mode = M_STYLE;
                    p_om   = 3'd2;
                end else begin
                    p_om   = '0;
                    p_cm   = '0;
                    p_mode = (p_c == C_GT) ? M_TEXT : M_TAG;
                    if (p_c == C_GT && r_pg != G_LINE) p_pg = G_SPACE;
                end
            end
            M_COMMENT, M_SCRIPT, M_STYLE: begin
                if (r_om < f_open_len(r_mode)) begin
                    p_want = f_open_char(r_mode, r_om);
                    if (((r_mode == M_COMMENT) ? p_c : p_lc) == p_want) begin
                        p_om = r_om + 3'd1;
                    end else begin
                        p_om   = '0;
                        p_cm   = '0;
                        p_mode = (p_c == C_GT) ? M_TEXT : M_TAG;
                        if (p_c == C_GT && r_pg != G_LINE) p_pg = G_SPACE;
                    end
                end else begin
                    p_want = f_close_char(r_mode, r_cm);
                    if (p_lc == p_want) begin
                        p_k = r_cm + 4'd1;
                        if (p_k >= f_close_len(r_mode)) begin
                            p_mode = M_TEXT;
                            p_om   = '0;
                            p_cm   = '0;
                            if (r_pg != G_LINE) p_pg = G_SPACE;
                        end else begin
                            p_cm = p_k;
                        end
                    end else if (r_mode == M_COMMENT) begin
                        p_cm = (r_cm == 4'd2 && p_c == C_DASH) ? 4'd2 : 4'd0;
                    end else begin
                        p_cm = (p_c == C_LT) ? 4'd1 : 4'd0;
                    end
                end
            end
            default: begin
                if (p_c == C_GT) begin
                    p_mode = M_TEXT;
                    p_om   = '0;
                    p_cm   = '0;
                    if (r_pg != G_LINE) p_pg = G_SPACE;
                end
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_c        = r_c;
        n_ws       = r_ws;
        n_last     = r_last;
        n_mode     = r_mode;
        n_om       = r_om;
        n_cm       = r_cm;
        n_pg       = r_pg;
        n_ec       = r_ec;
        n_eo       = r_eo;
        n_ds       = r_ds;
        n_rk       = r_rk;
        n_rn       = r_rn;
        n_from_end = r_from_end;
        e_v        = 1'b0;
        e_byte     = '0;
        e_mark     = 1'b0;
        fin        = 1'b0;
        pop_req    = 1'b0;
        h_we       = 1'b0;
        adv        = 1'b0;
        case (r_state)
            S_IDLE, S_FIN: begin
                fin     = r_state == S_FIN;
                n_state = S_IDLE;
                if (i_valid) begin
                    pop_req = 1'b1;
                    n_c     = i_item.in_byte;
                    n_ws    = i_item.ws;
                    n_last  = i_item.doc_end;
                    n_state = S_MAIN;
                    if (r_ds) begin
                        n_pg = i_item.initial_gap ? G_SPACE : G_NONE;
                        n_ds = 1'b0;
                    end
                end
            end
            S_MAIN: begin
                if (r_eo) begin
                    if (r_c == C_SEMI) begin
                        n_eo = 1'b0;
                        n_ec = '0;
                        if (r_pg != G_LINE) n_pg = G_SPACE;
                        adv = 1'b1;
                    end else if (r_ws || r_ec >= ENT_CW'(MAX_ENT)) begin
                        n_state    = S_AMP;
                        n_from_end = 1'b0;
                    end else begin
                        h_we = 1'b1;
                        n_ec = r_ec + ENT_CW'(1);
                        adv  = 1'b1;
                    end
                end else begin
                    n_mode = p_mode;
                    n_om   = p_om;
                    n_cm   = p_cm;
                    n_pg   = p_pg;
                    n_eo   = p_eo;
                    n_ec   = p_ec;
                    e_v    = p_emit;
                    e_byte = p_byte;
                    adv    = p_adv;
                end
                if (adv) begin
                    if (!r_last) begin
                        n_state = S_FIN;
                    end else if (n_eo) begin
                        n_state    = S_AMP;
                        n_from_end = 1'b1;
                    end else begin
                        n_state = S_MARK;
                    end
                end
            end
            S_AMP: begin
                e_v = 1'b1;
                if (r_pg != G_NONE) begin
                    e_byte = gap_byte;
                    n_pg   = G_NONE;
                end else begin
                    e_byte  = C_AMP;
                    n_eo    = 1'b0;
                    n_ec    = '0;
                    n_rn    = r_ec;
                    n_rk    = '0;
                    n_state = S_RPL;
                end
            end
            S_RPL: begin
                if (r_rk == r_rn) begin
                    n_state = r_from_end ? S_MARK : S_MAIN;
                end else begin
                    n_mode = p_mode;
                    n_om   = p_om;
                    n_cm   = p_cm;
                    n_pg   = p_pg;
                    e_v    = p_emit;
                    e_byte = p_byte;
                    if (p_adv) n_rk = r_rk + ENT_CW'(1);
                end
            end
            S_MARK: begin
                e_v     = 1'b1;
                e_mark  = 1'b1;
                n_mode  = M_TEXT;
                n_om    = '0;
                n_cm    = '0;
                n_pg    = G_NONE;
                n_ec    = '0;
                n_eo    = 1'b0;
                n_ds    = 1'b1;
                n_state = S_FIN;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign out_free = !r_out_v || o_out.ready;
    assign stall    = r_stg_v && !out_free && (e_v || fin);
    assign go       = !stall;
    assign o_pop    = pop_req && go;

    always_ff @(posedge i_clk) begin
        if (go && h_we) begin
            r_hold[r_ec[ENT_AW-1:0]] <= r_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_c    <= n_c;
            r_ws   <= n_ws;
            r_last <= n_last;
        end
        if (go && e_v) begin
            r_stg_byte <= e_byte;
            r_stg_mark <= e_mark;
        end
        if (go && r_stg_v && (e_v || fin)) begin
            r_out_byte <= r_stg_byte;
            r_out_mark <= r_stg_mark;
            r_out_last <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mode     <= M_TEXT;
            r_om       <= '0;
            r_cm       <= '0;
            r_pg       <= G_NONE;
            r_ec       <= '0;
            r_eo       <= 1'b0;
            r_ds       <= 1'b1;
            r_rk       <= '0;
            r_rn       <= '0;
            r_from_end <= 1'b0;
            r_stg_v    <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            if (go) begin
                r_state    <= n_state;
                r_mode     <= n_mode;
                r_om       <= n_om;
                r_cm       <= n_cm;
                r_pg       <= n_pg;
                r_ec       <= n_ec;
                r_eo       <= n_eo;
                r_ds       <= n_ds;
                r_rk       <= n_rk;
                r_rn       <= n_rn;
                r_from_end <= n_from_end;
                if (e_v) begin
                    r_stg_v <= 1'b1;
                end else if (fin) begin
                    r_stg_v <= 1'b0;
                end
            end
            if (go && r_stg_v && (e_v || fin)) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_out_v;
    assign o_out.out_byte    = r_out_byte;
    assign o_out.end_marker  = r_out_mark;
    assign o_out.last_of_run = r_out_last;

    `HMS_ASSERT(a_idle_flushed, (r_state == S_IDLE) |-> !r_stg_v, "Staged result left behind at idle.")
    `HMS_ASSERT(a_replay_bound, r_rk <= r_rn && r_rn <= ENT_CW'(MAX_ENT), "Replay index out of range.")
    `HMS_ASSERT(a_ent_bound, r_ec <= ENT_CW'(MAX_ENT), "Entity count above its limit.")
    `HMS_ASSERT(a_replay_closed, (r_state == S_RPL) |-> !r_eo, "Entity still open during replay.")

endmodule

>>> sv/html_markup_stripper_top.sv
// Strips HTML markup from a byte stream: comments, script and style blocks and tags are
// removed, they and closed entities become a single separator, and whitespace runs collapse.
// A failed entity is sent as its ampersand, and its held bytes are then replayed through the
// parser. A byte that emits a pending separator before itself, the end marker after the last
// beat of a document, and a failed entity with its replay each hold the sequencer before it
// takes the next beat. A four-entry queue decouples intake from the sequencer, and a staged
// result plus an output register let the last result of a beat be flagged before it is sent.
module html_markup_stripper_top
    import hms_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    hms_in_if.sink    i_in,
    hms_out_if.source o_out
);

    t_item item;
    logic  item_valid;
    logic  item_pop;

    hms_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_item  (item),
        .o_valid (item_valid),
        .i_pop   (item_pop)
    );

    hms_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item),
        .i_valid (item_valid),
        .o_pop   (item_pop),
        .o_out   (o_out)
    );

endmodule

>>> bench/tb_html_markup_stripper_top.sv
module tb_html_markup_stripper_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hms_pkg::*;

    typedef struct {
        logic [7:0] text;
        logic       marker;
        logic       last;
    } t_text_out;

    localparam int HOLD_LEN    = 24;
    localparam int STALL_LIMIT = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hms_in_if  in_if();
    hms_out_if out_if();

    html_markup_stripper_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_text_out  text_expected[$];
    int         mismatches = 0;
    int         stall_cycles = 0;
    bit         no_idle = 1'b0;
    bit         drain_hold = 1'b0;
    bit         failed = 1'b0;

    logic [2:0] scan_mode;
    logic [2:0] open_cnt;
    logic [3:0] close_cnt;
    logic [1:0] gap_kind;
    logic [7:0] amp_hold [HOLD_LEN];
    int         amp_cnt;
    bit         amp_open;
    bit         at_doc_start;
    t_text_out  step_out[$];

    function automatic logic [7:0] fold(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0B || c == 8'h0C || c == 8'h0D;
    endfunction

    function automatic void clear_predictor();
        scan_mode = M_TEXT;
        open_cnt = '0;
        close_cnt = '0;
        gap_kind = G_NONE;
        amp_cnt = 0;
        amp_open = 1'b0;
        at_doc_start = 1'b1;
    endfunction

    function automatic void push_text(input logic [7:0] b, input logic m);
        t_text_out r;
        r.text = b;
        r.marker = m;
        r.last = 1'b0;
        step_out.push_back(r);
    endfunction

    function automatic void emit_char(input logic [7:0] c);
        if (gap_kind != G_NONE) push_text(gap_kind == G_LINE ? C_NL : C_SP, 1'b0);
        gap_kind = G_NONE;
        push_text(c, 1'b0);
    endfunction

    function automatic void add_space();
        if (gap_kind != G_LINE) gap_kind = G_SPACE;
    endfunction

    function automatic void end_markup();
        scan_mode = M_TEXT;
        open_cnt = '0;
        close_cnt = '0;
        add_space();
    endfunction

    function automatic void break_opening(input logic [7:0] c);
        open_cnt = '0;
        close_cnt = '0;
        if (c == C_GT) end_markup();
        else scan_mode = M_TAG;
    endfunction

    function automatic void scan_char(input logic [7:0] c, input bit amp_live);
        string      name;
        string      closer;
        logic [7:0] got;
        int         k;
        case (scan_mode)
            M_TEXT: begin
                if (c == C_LT) begin
                    scan_mode = M_LT;
                    open_cnt = '0;
                    close_cnt = '0;
                end else if (c == C_AMP && amp_live) begin
                    amp_open = 1'b1;
                    amp_cnt = 0;
                end else if (c == C_NL) begin
                    gap_kind = G_LINE;
                end else if (is_space(c)) begin
                    add_space();
                end else begin
                    emit_char(c);
                end
            end
            M_LT: begin
                if (open_cnt == 0) begin
                    if (c == C_BANG) begin
                        scan_mode = M_COMMENT;
                        open_cnt = 3'd1;
                    end else if (fold(c) == "s") begin
                        open_cnt = 3'd1;
                    end else begin
                        break_opening(c);
                    end
                end else if (fold(c) == "c") begin
                    scan_mode = M_SCRIPT;
                    open_cnt = 3'd2;
                end else if (fold(c) == "t") begin
                    scan_mode = M_STYLE;
                    open_cnt = 3'd2;
                end else begin
                    break_opening(c);
                end
            end
            M_COMMENT, M_SCRIPT, M_STYLE: begin
                name = scan_mode == M_COMMENT ? "!--" : scan_mode == M_SCRIPT ? "script" : "style";
                closer = scan_mode == M_COMMENT ? "-->" :
                         scan_mode == M_SCRIPT ? "</script>" : "</style>";
                if (open_cnt < name.len()) begin
                    got = scan_mode == M_COMMENT ? c : fold(c);
                    if (got == name[open_cnt]) open_cnt++;
                    else break_opening(c);
                end else begin
                    k = close_cnt;
                    if (fold(c) == closer[k]) begin
                        k++;
                        if (k >= closer.len()) begin
                            end_markup();
                            return;
                        end
                    end else if (scan_mode == M_COMMENT) begin
                        k = (k == 2 && c == C_DASH) ? 2 : 0;
                    end else begin
                        k = (c == C_LT) ? 1 : 0;
                    end
                    close_cnt = 4'(k);
                end
            end
            default: if (c == C_GT) end_markup();
        endcase
    endfunction

    function automatic void replay_entity();
        int n;
        n = amp_cnt;
        amp_open = 1'b0;
        amp_cnt = 0;
        emit_char(C_AMP);
        for (int k = 0; k < n; k++) scan_char(amp_hold[k], 1'b0);
    endfunction

    function automatic void predict_text(input logic [7:0] c, input logic last_byte,
                                         input logic gap0);
        step_out.delete();
        if (at_doc_start) begin
            gap_kind = gap0 ? G_SPACE : G_NONE;
            at_doc_start = 1'b0;
        end
        if (amp_open) begin
            if (c == C_SEMI) begin
                amp_open = 1'b0;
                amp_cnt = 0;
                add_space();
            end else if (is_space(c) || amp_cnt >= HOLD_LEN) begin
                replay_entity();
                scan_char(c, 1'b1);
            end else begin
                amp_hold[amp_cnt] = c;
                amp_cnt++;
            end
        end else begin
            scan_char(c, 1'b1);
        end
        if (last_byte) begin
            if (amp_open) replay_entity();
            push_text(8'h00, 1'b1);
            clear_predictor();
        end
        if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i]) text_expected.push_back(step_out[i]);
    endfunction

    initial begin
        in_if.valid = 1'b0;
        in_if.in_byte = '0;
        in_if.doc_end = 1'b0;
        in_if.initial_gap = 1'b0;
        out_if.ready = 1'b0;
        clear_predictor();
    end

    always @(posedge i_clk) begin
        if (drain_hold) out_if.ready <= 1'b0;
        else out_if.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 23);
    end

    always @(posedge i_clk) begin
        t_text_out want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (text_expected.size() == 0) begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected output beat byte=%h end=%b last=%b",
                             out_if.out_byte, out_if.end_marker, out_if.last_of_run);
            end else begin
                want = text_expected.pop_front();
                if (out_if.out_byte !== want.text || out_if.end_marker !== want.marker ||
                    out_if.last_of_run !== want.last) begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: expected byte=%h end=%b last=%b, got byte=%h end=%b last=%b",
                                 want.text, want.marker, want.last, out_if.out_byte,
                                 out_if.end_marker, out_if.last_of_run);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("ERROR: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_beat(input logic [7:0] c, input logic last_byte, input logic gap0);
        if (!no_idle && $urandom_range(99) < 23) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.in_byte <= c;
        in_if.doc_end <= last_byte;
        in_if.initial_gap <= gap0;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_text(c, last_byte, gap0);
    endtask

    task automatic send_doc(input logic [7:0] doc[$], input bit gap0);
        foreach (doc[i])
            send_beat(doc[i], i == doc.size() - 1, i == 0 ? gap0 : 1'($urandom_range(1)));
    endtask

    task automatic send_str(input string s, input bit gap0);
        logic [7:0] doc[$];
        for (int i = 0; i < s.len(); i++) doc.push_back(s[i]);
        send_doc(doc, gap0);
    endtask

    task automatic test_directed();
        logic [7:0] doc[$];
        send_str("Hi \n<b>b</b> y&amp;z &lt w&", 1'b1);
        send_str("<!--c--->b<SCRIPT><y</ScRiPt>c", 1'b0);
        send_str("<Style>q</STYLE ></style>r&<b>;c&&q;", 1'b0);
        send_str("v&abcdefghijklmnopqrstuvwxyz w", 1'b0);
        send_str("<!x>a<sx>b<s>e<>f", 1'b1);
        send_str("n<script>o", 1'b0);
        send_str("t \t\v\f\r\n ", 1'b1);
        doc = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'hC1};
        send_doc(doc, 1'b1);
        doc = '{8'hFF};
        send_doc(doc, 1'b0);
    endtask

    task automatic test_random_docs(input int beats);
        logic [7:0] doc[$];
        string      parts[] = '{"word", "Text", " ", "\n", "<p>", "</div>", "<!--c-->",
                                "<script>a<b</script>", "<STYLE>x</Style>", "&amp;", "&nb ",
                                "&", ";", "<", ">", "-", "<s", "<!-", "\t"};
        string      p;
        int         sent = 0;
        while (sent < beats) begin
            doc.delete();
            repeat ($urandom_range(8, 1)) begin
                if ($urandom_range(99) < 75) begin
                    p = parts[$urandom_range(parts.size() - 1)];
                    for (int i = 0; i < p.len(); i++) doc.push_back(p[i]);
                end else begin
                    doc.push_back(8'($urandom_range(255)));
                end
            end
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(30, 20)) doc.push_back("e");
            send_doc(doc, 1'($urandom_range(1)));
            sent += doc.size();
        end
    endtask

    task automatic test_output_stall();
        no_idle = 1'b1;
        fork
            begin
                drain_hold = 1'b1;
                repeat (300) @(posedge i_clk);
                drain_hold = 1'b0;
            end
            send_str("st <i>t</i> &amp; ok", 1'b0);
        join
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_output_stall();
        no_idle = 1'b1;
        test_random_docs(8);
        no_idle = 1'b0;
        test_random_docs(12);
        in_if.valid <= 1'b0;
        while (text_expected.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (!failed && text_expected.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+sv
sv/hms_pkg.sv
sv/hms_if.sv
sv/hms_front.sv
sv/hms_back.sv
sv/html_markup_stripper_top.sv
bench/tb_html_markup_stripper_top.sv
